### src/wtdds_pkg.sv
// Shared types and constants for the three-channel wavetable oscillator.
// No dependencies; every other file imports this package.
`default_nettype none

package wtdds_pkg;

   // Sizes of the oscillator
   localparam int TABLE_DEPTH   = 256;
   localparam int CHANNEL_COUNT = 3;
   localparam int PHASE_BITS    = 16;
   localparam int OUT_FIELDS    = 3;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);

   // Field widths of the transactions
   localparam int SEL_BITS   = 2;
   localparam int INDEX_BITS = 8;
   localparam int BYTE_BITS  = 8;
   localparam int STEP_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   // Small queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [STEP_BITS-1:0]  STEP_RESET   = STEP_BITS'(100);
   localparam logic [OUT_FIELDS-1:0] ENABLE_RESET = '0;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_STEP_A         = 2'd0,
      REG_STEP_B         = 2'd1,
      REG_STEP_C         = 2'd2,
      REG_CHANNEL_ENABLE = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic                  kind;
      logic [SEL_BITS-1:0]   table_select;
      logic [INDEX_BITS-1:0] table_index;
      logic [BYTE_BITS-1:0]  table_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] duty_a;
      logic [BYTE_BITS-1:0] duty_b;
      logic [BYTE_BITS-1:0] duty_c;
   } rsp_type;

   // Classified command held in the queue
   typedef struct packed {
      logic                 is_write;
      logic [SEL_BITS-1:0]  sel;
      logic [ADDR_BITS-1:0] addr;
      logic [BYTE_BITS-1:0] value;
   } cmd_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [OUT_FIELDS-1:0][STEP_BITS-1:0] step;
      logic [OUT_FIELDS-1:0]                enable;
   } csr_type;

endpackage

`default_nettype wire

### src/wtdds_front.sv
// Front end: configuration registers and classification of incoming transactions.
// Depends on wtdds_pkg; feeds wtdds_queue and hands the configuration to wtdds_back.
`default_nettype none

module wtdds_front
   import wtdds_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [STEP_BITS-1:0]    csr_wdata,
   input  wire logic                    q_full,
   output logic                         q_push,
   output cmd_type                      q_push_data,
   output csr_type                      csr
);

   csr_type csr_ff, csr_in;
   logic    accept;
   logic    drop;

   // Update a register on a write; bits of the data beyond the enable field are masked off
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_STEP_A:         csr_in.step[0] = csr_wdata;
            REG_STEP_B:         csr_in.step[1] = csr_wdata;
            REG_STEP_C:         csr_in.step[2] = csr_wdata;
            REG_CHANNEL_ENABLE: csr_in.enable  = csr_wdata[OUT_FIELDS-1:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.step   <= {OUT_FIELDS{STEP_RESET}};
         csr_ff.enable <= ENABLE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

   // Classify: drop writes to an absent table or beyond its depth
   always_comb begin
      drop = 1'b0;
      if (req_data.kind == KIND_WRITE) begin
         if (32'(req_data.table_select) >= CHANNEL_COUNT ||
             32'(req_data.table_select) >= OUT_FIELDS ||
             32'(req_data.table_index) >= TABLE_DEPTH) begin
            drop = 1'b1;
         end
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && !drop;

   always_comb begin
      q_push_data.is_write = (req_data.kind == KIND_WRITE);
      q_push_data.sel      = req_data.table_select;
      q_push_data.addr     = ADDR_BITS'(req_data.table_index);
      q_push_data.value    = req_data.table_value;
   end

endmodule

`default_nettype wire

### src/wtdds_queue.sv
// Short command queue between front and back end.
// Depends on wtdds_pkg for the command type and queue depth.
`default_nettype none

module wtdds_queue
   import wtdds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_data
);

   cmd_type              q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_pop;

   assign full      = (32'(count_ff) == QUEUE_DEPTH);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = q_mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/wtdds_back.sv
// Back end: per-channel wavetable memories, phase accumulators and the result register.
// Depends on wtdds_pkg; takes commands from wtdds_queue and configuration from wtdds_front.
`default_nettype none

module wtdds_back
   import wtdds_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire csr_type csr,
   input  wire logic    q_valid,
   input  wire cmd_type q_data,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic                 rd_vld_ff, rd_vld_in;
   logic [OUT_FIELDS-1:0] rd_mask_ff, rd_mask_in;
   logic [BYTE_BITS-1:0] rd_data [OUT_FIELDS];
   logic [BYTE_BITS-1:0] duty [OUT_FIELDS];
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 out_free;
   logic                 advance;
   logic                 tick_go;
   logic                 write_go;

   // Pipeline control: the read stage moves on when the result slot frees
   assign out_free = !rsp_vld_ff || rsp_ready;
   assign advance  = !rd_vld_ff || out_free;
   assign q_pop    = q_valid && advance;
   assign tick_go  = q_pop && !q_data.is_write;
   assign write_go = q_pop && q_data.is_write;

   // One table memory and one phase accumulator per channel
   for (genvar ch = 0; ch < OUT_FIELDS; ch++) begin : g_chan
      if (ch < CHANNEL_COUNT) begin : g_live
         logic [BYTE_BITS-1:0]  wave_mem [TABLE_DEPTH];
         logic [BYTE_BITS-1:0]  rd_data_ff;
         logic [PHASE_BITS-1:0] phase_ff, phase_in;
         logic                  wr_en;
         logic [ADDR_BITS-1:0]  rd_addr;

         assign wr_en   = write_go && (32'(q_data.sel) == ch);
         assign rd_addr = phase_ff[PHASE_BITS-1 -: ADDR_BITS];

         // Write a table byte, or read the entry under the phase on a tick
         always_ff @(posedge clock) begin
            if (wr_en) begin
               wave_mem[q_data.addr] <= q_data.value;
            end
            if (tick_go) begin
               rd_data_ff <= wave_mem[rd_addr];
            end
         end

         // Advance the phase of an enabled channel; hold it otherwise
         always_comb begin
            phase_in = phase_ff;
            if (tick_go && csr.enable[ch]) begin
               phase_in = phase_ff + PHASE_BITS'(csr.step[ch]);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= '0;
            end else begin
               phase_ff <= phase_in;
            end
         end

         assign rd_data[ch] = rd_data_ff;
      end else begin : g_absent
         assign rd_data[ch] = '0;
      end
   end

   // Read stage occupancy and enable mask
   always_comb begin
      rd_vld_in  = rd_vld_ff;
      rd_mask_in = rd_mask_ff;
      if (tick_go) begin
         rd_vld_in  = 1'b1;
         rd_mask_in = csr.enable;
      end else if (rd_vld_ff && out_free) begin
         rd_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rd_mask_ff <= '0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         rd_mask_ff <= rd_mask_in;
      end
   end

   // Zero the samples of disabled channels
   always_comb begin
      for (int ch = 0; ch < OUT_FIELDS; ch++) begin
         duty[ch] = rd_mask_ff[ch] ? rd_data[ch] : '0;
      end
   end

   // Result register: load from the read stage, drop once taken
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rd_vld_ff && out_free) begin
         rsp_vld_in         = 1'b1;
         rsp_data_in.duty_a = duty[0];
         rsp_data_in.duty_b = duty[1];
         rsp_data_in.duty_c = duty[2];
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/three_channel_wavetable_dds.sv
// Three-channel wavetable oscillator, top level.
// A tick accepted by the front end passes the command queue, the table read and the
// result register before its result is valid. Throughput: one transaction per cycle while
// results are taken, set by the single read port of each channel's table memory and one
// phase adder per channel. Reset (synchronous): steps return to 100, channels disabled,
// phases zero, queue empty. Table contents are not cleared and must be written first.
`default_nettype none

module three_channel_wavetable_dds
   import wtdds_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_type                      rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [STEP_BITS-1:0]    csr_wdata
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_data;
   csr_type csr;

   wtdds_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .csr         (csr)
   );

   wtdds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   wtdds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### tb/tb_three_channel_wavetable_dds.sv
// Self-checking testbench for the three-channel wavetable oscillator.
// Depends on wtdds_pkg and three_channel_wavetable_dds; predicts every duty transaction.

module tb_three_channel_wavetable_dds;
   import wtdds_pkg::*;

   localparam int CYCLE_LIMIT       = 200000;
   localparam int DRAIN_CYCLES      = 4;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int SETTING_COUNT     = 8;
   localparam int ITEMS_PER_SETTING = 96;
   localparam int HOLD_SETTING      = 2;
   localparam int STEADY_SETTING    = 4;
   localparam int IDLE_PERCENT      = 24;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_TICK_TYPED,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type           what;
      req_type                item;
      csr_reg_type            reg_sel;
      logic [STEP_BITS-1:0]   wdata;
      rsp_type                duty;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [STEP_BITS-1:0]    csr_wdata;

   // Shadow state of the oscillator
   logic [STEP_BITS-1:0]  step_shadow  [OUT_FIELDS];
   logic [OUT_FIELDS-1:0] enable_shadow;
   logic [PHASE_BITS-1:0] phase_shadow [CHANNEL_COUNT];
   logic [BYTE_BITS-1:0]  wave_shadow  [CHANNEL_COUNT][TABLE_DEPTH];

   rsp_type      duty_expect_q [$];
   plan_row_type directed_plan [$];
   int           failures;
   int           cycle_count;
   bit           steady;
   bit           hold_off_request;
   bit           hold_off_done;

   three_channel_wavetable_dds dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Apply one transaction to the shadow state; a tick yields three duty samples
   function automatic void apply_transaction(input req_type item, output bit gives_duty,
                                             output rsp_type duty);
      logic [ADDR_BITS-1:0] addr;
      logic [BYTE_BITS-1:0] sample [OUT_FIELDS];
      gives_duty = 1'b0;
      duty = '0;
      if (item.kind == KIND_WRITE) begin
         // select of 3 drops the write
         if (item.table_select < SEL_BITS'(CHANNEL_COUNT))
            wave_shadow[item.table_select][item.table_index] = item.table_value;
         return;
      end
      for (int ch = 0; ch < OUT_FIELDS; ch++) begin
         sample[ch] = '0;
         if (enable_shadow[ch]) begin
            addr = phase_shadow[ch][PHASE_BITS-1 -: ADDR_BITS];
            sample[ch] = wave_shadow[ch][addr];
            phase_shadow[ch] = phase_shadow[ch] + step_shadow[ch];
         end
      end
      gives_duty = 1'b1;
      duty.duty_a = sample[0];
      duty.duty_b = sample[1];
      duty.duty_c = sample[2];
   endfunction

   function automatic plan_row_type put_byte(input logic [SEL_BITS-1:0] sel,
                                             input logic [INDEX_BITS-1:0] idx,
                                             input logic [BYTE_BITS-1:0] value);
      plan_row_type row;
      row = '0;
      row.what = ROW_ITEM;
      row.item.kind = KIND_WRITE;
      row.item.table_select = sel;
      row.item.table_index = idx;
      row.item.table_value = value;
      return row;
   endfunction

   function automatic plan_row_type free_tick();
      plan_row_type row;
      row = '0;
      row.what = ROW_ITEM;
      row.item.kind = KIND_TICK;
      return row;
   endfunction

   function automatic plan_row_type check_tick(input logic [BYTE_BITS-1:0] a,
                                               input logic [BYTE_BITS-1:0] b,
                                               input logic [BYTE_BITS-1:0] c);
      plan_row_type row;
      row = free_tick();
      row.what = ROW_TICK_TYPED;
      row.duty = rsp_type'{a, b, c};
      return row;
   endfunction

   function automatic plan_row_type set_reg(input csr_reg_type which,
                                            input logic [STEP_BITS-1:0] value);
      plan_row_type row;
      row = '0;
      row.what = ROW_CSR;
      row.reg_sel = which;
      row.wdata = value;
      return row;
   endfunction

   function automatic logic [STEP_BITS-1:0] pick_step();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return STEP_BITS'(1);
         3: return STEP_BITS'(TABLE_DEPTH);
         default: return STEP_BITS'($urandom_range(65535));
      endcase
   endfunction

   // Offer one transaction, hold it until accepted, then predict its outcome
   task automatic offer_transaction(input req_type item, output bit gives_duty,
                                    output rsp_type duty);
      if (!steady)
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_transaction(item, gives_duty, duty);
   endtask

   // Drop valid and wait until every duty transaction has come back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (duty_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_reg_type which, input logic [STEP_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      if (which == REG_CHANNEL_ENABLE)
         enable_shadow = value[OUT_FIELDS-1:0];
      else
         step_shadow[which] = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random back-pressure, one long hold-off, none while steady
   initial begin
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_off_done) begin
            rsp_ready <= 1'b0;
            for (held = 1; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Check each duty transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_expect_q.size() == 0) begin
            $error("unexpected duty transaction %h", rsp_data);
            failures++;
         end else begin
            want = duty_expect_q.pop_front();
            if (rsp_data.duty_a !== want.duty_a) begin
               $error("duty_a: expected %0d, got %0d", want.duty_a, rsp_data.duty_a);
               failures++;
            end
            if (rsp_data.duty_b !== want.duty_b) begin
               $error("duty_b: expected %0d, got %0d", want.duty_b, rsp_data.duty_b);
               failures++;
            end
            if (rsp_data.duty_c !== want.duty_c) begin
               $error("duty_c: expected %0d, got %0d", want.duty_c, rsp_data.duty_c);
               failures++;
            end
         end
      end
   end

   initial begin
      plan_row_type row;
      req_type      item;
      bit           gives_duty;
      rsp_type      duty;
      int           placed;
      int           roll;
      int           slot;
      logic [OUT_FIELDS-1:0] enable_value;

      failures = 0;
      cycle_count = 0;
      steady = 1'b0;
      hold_off_request = 1'b0;
      hold_off_done = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;

      for (int ch = 0; ch < OUT_FIELDS; ch++) step_shadow[ch] = STEP_RESET;
      enable_shadow = ENABLE_RESET;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) phase_shadow[ch] = '0;

      // Directed rows: table extremes, bad select, enable masking, step extremes
      directed_plan = '{
         check_tick(8'h00, 8'h00, 8'h00),
         put_byte(2'd0, 8'd0, 8'hFF),
         put_byte(2'd1, 8'd0, 8'h00),
         put_byte(2'd2, 8'd0, 8'hA5),
         put_byte(2'd3, 8'd0, 8'h33),
         put_byte(2'd0, 8'd255, 8'h5A),
         put_byte(2'd1, 8'd255, 8'hC3),
         put_byte(2'd2, 8'd255, 8'h3C),
         set_reg(REG_STEP_A, 16'h0000),
         set_reg(REG_STEP_B, 16'h0000),
         set_reg(REG_STEP_C, 16'h0000),
         set_reg(REG_CHANNEL_ENABLE, 16'h0007),
         check_tick(8'hFF, 8'h00, 8'hA5),
         check_tick(8'hFF, 8'h00, 8'hA5),
         set_reg(REG_CHANNEL_ENABLE, 16'hFFFD),
         set_reg(REG_STEP_A, 16'hFFFF),
         set_reg(REG_STEP_C, 16'hFFFF),
         check_tick(8'hFF, 8'h00, 8'hA5),
         check_tick(8'h5A, 8'h00, 8'h3C),
         free_tick(),
         set_reg(REG_CHANNEL_ENABLE, 16'h0000),
         check_tick(8'h00, 8'h00, 8'h00)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         if (row.what == ROW_CSR) begin
            wait_for_idle();
            write_register(row.reg_sel, row.wdata);
         end else begin
            offer_transaction(row.item, gives_duty, duty);
            if (gives_duty)
               duty_expect_q.push_back(row.what == ROW_TICK_TYPED ? row.duty : duty);
         end
      end

      // Fill every table entry before any random tick can read one
      for (int ch = 0; ch < CHANNEL_COUNT; ch++)
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            item.kind = KIND_WRITE;
            item.table_select = SEL_BITS'(ch);
            item.table_index = INDEX_BITS'((i * 167) % TABLE_DEPTH);
            item.table_value = BYTE_BITS'($urandom_range(255));
            offer_transaction(item, gives_duty, duty);
         end

      // Random phases, each with its own steps and enable mask
      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         wait_for_idle();
         enable_value = OUT_FIELDS'(setting) ^ '1;
         for (int ch = 0; ch < OUT_FIELDS; ch++) begin
            if (setting == 0)
               write_register(csr_reg_type'(ch), '1);
            else if (setting == 1)
               write_register(csr_reg_type'(ch), '0);
            else
               write_register(csr_reg_type'(ch), pick_step());
         end
         write_register(REG_CHANNEL_ENABLE,
                        {13'($urandom_range(8191)), enable_value});
         steady = (setting == STEADY_SETTING);
         placed = 0;
         while (placed < ITEMS_PER_SETTING) begin
            if (setting == HOLD_SETTING && placed == 10)
               hold_off_request = 1'b1;
            roll = $urandom_range(99);
            slot = $urandom_range(CHANNEL_COUNT - 1);
            item.table_index = INDEX_BITS'($urandom_range(255));
            item.table_value = BYTE_BITS'($urandom_range(255));
            if (roll < 55) begin
               item.kind = KIND_TICK;
               item.table_select = SEL_BITS'($urandom_range(3));
            end else begin
               item.kind = KIND_WRITE;
               item.table_select = (roll < 92) ? SEL_BITS'(slot) : '1;
            end
            offer_transaction(item, gives_duty, duty);
            if (gives_duty) duty_expect_q.push_back(duty);
            if (!(item.kind == KIND_WRITE && item.table_select == '1))
               placed++;
         end
         steady = 1'b0;
      end

      wait_for_idle();
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
